// File: rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, constants and helper functions of the tilt-compensated compass.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES   = 16;
  localparam int TABLE_LEN       = 24;
  localparam int CORDIC_N        = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int SHW             = $clog2(TABLE_LEN);

  localparam int SQRT_STEPS = 32;
  localparam int RMW        = 36;
  localparam int VW         = 52;
  localparam int ZW         = 34;
  localparam int RW         = 34;
  localparam int PW         = 48;
  localparam int SCW        = 32;

  localparam longint PI_L      = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint GAIN_L    = 64'sd652032874;

  localparam logic signed [ZW-1:0] PI_Q30      = ZW'(PI_L);
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(HALF_PI_L);
  localparam logic signed [RW-1:0] GAIN_Q30    = RW'(GAIN_L);

  localparam int     OUT_SH     = 30 - ANGLE_FRAC_BITS;
  localparam longint OUT_HALF_L = 64'sd1 <<< (OUT_SH - 1);
  localparam longint OUT_LIM_L  = (PI_L + OUT_HALF_L) >>> OUT_SH;
  localparam logic signed [ZW:0] OUT_HALF = (ZW+1)'(OUT_HALF_L);
  localparam logic signed [ZW:0] OUT_LIM  = (ZW+1)'(OUT_LIM_L);
  localparam logic signed [15:0] OUT_LIM16 = 16'(OUT_LIM_L);

  typedef struct packed {
    logic [31:0]    rad;
    logic [RMW-1:0] rem;
    logic [31:0]    root;
  } sqrt_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } rot_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic signed [15:0] hz;
  } side_t;

  typedef struct packed {
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic signed [15:0] hz;
  } mag_t;

  typedef struct packed {
    logic signed [ZW-1:0] pitch;
    logic signed [ZW-1:0] roll;
  } ang_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [SHW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(64'sd843314857);
      5'd1:    v = ZW'(64'sd497837829);
      5'd2:    v = ZW'(64'sd263043837);
      5'd3:    v = ZW'(64'sd133525159);
      5'd4:    v = ZW'(64'sd67021687);
      5'd5:    v = ZW'(64'sd33543516);
      5'd6:    v = ZW'(64'sd16775851);
      5'd7:    v = ZW'(64'sd8388437);
      5'd8:    v = ZW'(64'sd4194283);
      5'd9:    v = ZW'(64'sd2097149);
      5'd10:   v = ZW'(64'sd1048576);
      5'd11:   v = ZW'(64'sd524288);
      5'd12:   v = ZW'(64'sd262144);
      5'd13:   v = ZW'(64'sd131072);
      5'd14:   v = ZW'(64'sd65536);
      5'd15:   v = ZW'(64'sd32768);
      5'd16:   v = ZW'(64'sd16384);
      5'd17:   v = ZW'(64'sd8192);
      5'd18:   v = ZW'(64'sd4096);
      5'd19:   v = ZW'(64'sd2048);
      5'd20:   v = ZW'(64'sd1024);
      5'd21:   v = ZW'(64'sd512);
      5'd22:   v = ZW'(64'sd256);
      5'd23:   v = ZW'(64'sd128);
      default: v = '0;
    endcase
    return v;
  endfunction

  // quadrant fix for vectoring: left half plane turned by a quarter turn
  function automatic vec_t prerot(input logic signed [VW-1:0] y,
                                  input logic signed [VW-1:0] x);
    vec_t v;
    v.x    = x;
    v.y    = y;
    v.z    = '0;
    v.zero = (x == '0) && (y == '0);
    if (x[VW-1]) begin
      if (!y[VW-1]) begin
        v.x = y;
        v.y = -x;
        v.z = HALF_PI_Q30;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -HALF_PI_Q30;
      end
    end
    return v;
  endfunction

  function automatic rot_t fold(input logic signed [ZW-1:0] z);
    rot_t r;
    r.x   = GAIN_Q30;
    r.y   = '0;
    r.z   = z;
    r.neg = 1'b0;
    if (z > HALF_PI_Q30) begin
      r.z   = z - PI_Q30;
      r.neg = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      r.z   = z + PI_Q30;
      r.neg = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [ZW-1:0] a);
    logic signed [ZW:0] t;
    logic signed [ZW:0] r;
    t = {a[ZW-1], a} + OUT_HALF;
    r = t >>> OUT_SH;
    if (r > OUT_LIM) begin
      r = OUT_LIM;
    end else if (r < -OUT_LIM) begin
      r = -OUT_LIM;
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/tcc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tcc_sqrt_cell
// One digit step of the restoring square root, one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  tcc_pkg::sqrt_t d,
  output tcc_pkg::sqrt_t q
);

  tcc_pkg::sqrt_t           sq_r;
  tcc_pkg::sqrt_t           sq_nxt;
  logic [tcc_pkg::RMW-1:0] cur;
  logic [tcc_pkg::RMW-1:0] trial;
  logic                    ge;

  always_comb begin
    cur         = {d.rem[tcc_pkg::RMW-3:0], d.rad[31:30]};
    trial       = {{(tcc_pkg::RMW-34){1'b0}}, d.root, 2'b01};
    ge          = (cur >= trial);
    sq_nxt.rad  = {d.rad[29:0], 2'b00};
    sq_nxt.rem  = ge ? (cur - trial) : cur;
    sq_nxt.root = {d.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign q = sq_r;

endmodule

`default_nettype wire

// File: rtl/tcc_vec_cell.sv
// ----------------------------------------------------------------------------
// tcc_vec_cell
// One CORDIC vectoring micro-rotation, driving y toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_vec_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic [tcc_pkg::SHW-1:0]         shamt,
  input  logic signed [tcc_pkg::ZW-1:0]   ang,
  input  tcc_pkg::vec_t                   d,
  output tcc_pkg::vec_t                   q
);

  tcc_pkg::vec_t                 vec_r;
  tcc_pkg::vec_t                 vec_nxt;
  logic signed [tcc_pkg::VW-1:0] dx;
  logic signed [tcc_pkg::VW-1:0] dy;

  always_comb begin
    dx           = d.y >>> shamt;
    dy           = d.x >>> shamt;
    vec_nxt.zero = d.zero;
    if (!d.y[tcc_pkg::VW-1]) begin
      vec_nxt.x = d.x + dx;
      vec_nxt.y = d.y - dy;
      vec_nxt.z = d.z + ang;
    end else begin
      vec_nxt.x = d.x - dx;
      vec_nxt.y = d.y + dy;
      vec_nxt.z = d.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign q = vec_r;

endmodule

`default_nettype wire

// File: rtl/tcc_rot_cell.sv
// ----------------------------------------------------------------------------
// tcc_rot_cell
// One CORDIC rotation micro-step, driving the residual angle toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_rot_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic [tcc_pkg::SHW-1:0]         shamt,
  input  logic signed [tcc_pkg::ZW-1:0]   ang,
  input  tcc_pkg::rot_t                   d,
  output tcc_pkg::rot_t                   q
);

  tcc_pkg::rot_t                 rot_r;
  tcc_pkg::rot_t                 rot_nxt;
  logic signed [tcc_pkg::RW-1:0] dx;
  logic signed [tcc_pkg::RW-1:0] dy;

  always_comb begin
    dx          = d.y >>> shamt;
    dy          = d.x >>> shamt;
    rot_nxt.neg = d.neg;
    if (!d.z[tcc_pkg::ZW-1]) begin
      rot_nxt.x = d.x - dx;
      rot_nxt.y = d.y + dy;
      rot_nxt.z = d.z - ang;
    end else begin
      rot_nxt.x = d.x + dx;
      rot_nxt.y = d.y - dy;
      rot_nxt.z = d.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  assign q = rot_r;

endmodule

`default_nettype wire

// File: rtl/tilt_compensated_compass.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass
// Pitch, roll and tilt-compensated heading from raw accelerometer and
// magnetometer triples, fully pipelined CORDIC datapath.
// ----------------------------------------------------------------------------
// One request per clock is accepted and every request gives exactly one
// result; the pipeline stalls as a whole while a result waits at the output.
// The datapath is an input register, a 32-cell square root, a prerotation
// register and two vectoring chains of N cells, with N the CORDIC stage
// count, a fold register and two rotation chains of N cells for sine and
// cosine, four product and sum stages, a prerotation register and a final
// vectoring chain of N cells for the heading, and the output register.
// Angles come out as signed radians with ANGLE_FRAC_BITS fraction bits,
// clamped to +-pi.
`default_nettype none

module tilt_compensated_compass (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_mag_x,
  input  logic signed [15:0] in_mag_y,
  input  logic signed [15:0] in_mag_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_yaw_angle
);

  localparam int N     = tcc_pkg::CORDIC_N;
  localparam int SQN   = tcc_pkg::SQRT_STEPS;
  localparam int VW    = tcc_pkg::VW;
  localparam int ZW    = tcc_pkg::ZW;
  localparam int PW    = tcc_pkg::PW;
  localparam int SCW   = tcc_pkg::SCW;
  localparam int SHW   = tcc_pkg::SHW;
  localparam int DEPTH = 3 * N + 41;
  localparam int ANGN  = 2 * N + 6;

  logic             adv;
  logic [DEPTH-1:0] vld_r;

  // input stage
  tcc_pkg::side_t     s0_r;
  logic [31:0]        sq0_r;
  logic signed [31:0] ax_w, az_w;

  // square root chain
  tcc_pkg::sqrt_t sqc [1:SQN];
  tcc_pkg::side_t sd_r [1:SQN];

  // pitch and roll vectoring
  tcc_pkg::vec_t pv0_r;
  tcc_pkg::vec_t rv0_r;
  tcc_pkg::vec_t pv [1:N];
  tcc_pkg::vec_t rv [1:N];
  tcc_pkg::mag_t hv_r [0:N];

  // sine / cosine rotation
  tcc_pkg::rot_t pr0_r;
  tcc_pkg::rot_t rr0_r;
  tcc_pkg::rot_t pr [1:N];
  tcc_pkg::rot_t rr [1:N];
  tcc_pkg::mag_t hr_r [0:N];
  tcc_pkg::ang_t ang_r [0:ANGN-1];

  logic signed [ZW-1:0] pitch_a;
  logic signed [ZW-1:0] roll_a;

  // sine / cosine results
  logic signed [SCW-1:0] sp_r, cp_r, sr_r, cr_r;
  tcc_pkg::mag_t         hn_r;

  // multiply stages
  logic signed [63:0]    srsp_p, srcp_p;
  logic signed [63:0]    srsp_s, srcp_s;
  logic signed [SCW-1:0] srsp_r, srcp_r;
  logic signed [PW-1:0]  hxcp_p, hzsp_p, hycr_p, hxss_p, hzsc_p;
  logic signed [PW-1:0]  hxcp_r, hzsp_r, hycr_r;
  logic signed [15:0]    hx1_r, hz1_r;
  logic signed [PW-1:0]  xh2_r, hxss_r, hzsc_r, hycr2_r;
  logic signed [PW-1:0]  xh3_r, yh3_r;

  // heading vectoring
  tcc_pkg::vec_t yv0_r;
  tcc_pkg::vec_t yv [1:N];

  logic signed [15:0] out_pitch_r, out_roll_r, out_yaw_r;
  logic signed [ZW-1:0] yaw_a;

  logic signed [16:0]   nax;
  logic signed [VW-1:0] p_y, p_x, r_y, r_x, y_y, y_x;

  assign out_valid = vld_r[DEPTH-1];
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // input capture and sum of squares
  assign ax_w = 32'(in_accel_x);
  assign az_w = 32'(in_accel_z);

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r  <= '{in_accel_x, in_accel_y, in_accel_z, in_mag_x, in_mag_y, in_mag_z};
      sq0_r <= ax_w * ax_w + az_w * az_w;
    end
  end

  genvar k;
  generate
    for (k = 0; k < SQN; k++) begin : g_sqrt
      if (k == 0) begin : g_first
        tcc_sqrt_cell u_cell (
          .clk (clk),
          .en  (adv),
          .d   ('{sq0_r, '0, '0}),
          .q   (sqc[1])
        );
      end else begin : g_next
        tcc_sqrt_cell u_cell (
          .clk (clk),
          .en  (adv),
          .d   (sqc[k]),
          .q   (sqc[k+1])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[1] <= s0_r;
      for (int i = 2; i <= SQN; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // vectoring inputs for pitch and roll
  always_comb begin
    nax = -{sd_r[SQN].ax[15], sd_r[SQN].ax};
    p_y = {{(VW-32){sd_r[SQN].ay[15]}}, sd_r[SQN].ay, 16'b0};
    p_x = {{(VW-32){1'b0}}, sqc[SQN].root};
    r_y = {{(VW-33){nax[16]}}, nax, 16'b0};
    r_x = {{(VW-32){sd_r[SQN].az[15]}}, sd_r[SQN].az, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pv0_r   <= tcc_pkg::prerot(p_y, p_x);
      rv0_r   <= tcc_pkg::prerot(r_y, r_x);
      hv_r[0] <= '{sd_r[SQN].hx, sd_r[SQN].hy, sd_r[SQN].hz};
      for (int i = 1; i <= N; i++) begin
        hv_r[i] <= hv_r[i-1];
      end
    end
  end

  genvar v;
  generate
    for (v = 0; v < N; v++) begin : g_vec
      if (v == 0) begin : g_first
        tcc_vec_cell u_pitch (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(v)),
          .ang   (tcc_pkg::atan_q30(SHW'(v))),
          .d     (pv0_r),
          .q     (pv[1])
        );
        tcc_vec_cell u_roll (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(v)),
          .ang   (tcc_pkg::atan_q30(SHW'(v))),
          .d     (rv0_r),
          .q     (rv[1])
        );
      end else begin : g_next
        tcc_vec_cell u_pitch (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(v)),
          .ang   (tcc_pkg::atan_q30(SHW'(v))),
          .d     (pv[v]),
          .q     (pv[v+1])
        );
        tcc_vec_cell u_roll (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(v)),
          .ang   (tcc_pkg::atan_q30(SHW'(v))),
          .d     (rv[v]),
          .q     (rv[v+1])
        );
      end
    end
  endgenerate

  assign pitch_a = pv[N].zero ? '0 : pv[N].z;
  assign roll_a  = rv[N].zero ? '0 : rv[N].z;

  always_ff @(posedge clk) begin
    if (adv) begin
      pr0_r    <= tcc_pkg::fold(pitch_a);
      rr0_r    <= tcc_pkg::fold(roll_a);
      hr_r[0]  <= hv_r[N];
      ang_r[0] <= '{pitch_a, roll_a};
      for (int i = 1; i <= N; i++) begin
        hr_r[i] <= hr_r[i-1];
      end
      for (int i = 1; i < ANGN; i++) begin
        ang_r[i] <= ang_r[i-1];
      end
    end
  end

  genvar r;
  generate
    for (r = 0; r < N; r++) begin : g_rot
      if (r == 0) begin : g_first
        tcc_rot_cell u_pitch (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(r)),
          .ang   (tcc_pkg::atan_q30(SHW'(r))),
          .d     (pr0_r),
          .q     (pr[1])
        );
        tcc_rot_cell u_roll (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(r)),
          .ang   (tcc_pkg::atan_q30(SHW'(r))),
          .d     (rr0_r),
          .q     (rr[1])
        );
      end else begin : g_next
        tcc_rot_cell u_pitch (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(r)),
          .ang   (tcc_pkg::atan_q30(SHW'(r))),
          .d     (pr[r]),
          .q     (pr[r+1])
        );
        tcc_rot_cell u_roll (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(r)),
          .ang   (tcc_pkg::atan_q30(SHW'(r))),
          .d     (rr[r]),
          .q     (rr[r+1])
        );
      end
    end
  endgenerate

  // unfold sign, then the magnetic rotation products
  assign srsp_p = sr_r * sp_r;
  assign srcp_p = sr_r * cp_r;
  assign srsp_s = srsp_p >>> 30;
  assign srcp_s = srcp_p >>> 30;
  assign hxcp_p = hn_r.hx * cp_r;
  assign hzsp_p = hn_r.hz * sp_r;
  assign hycr_p = hn_r.hy * cr_r;
  assign hxss_p = hx1_r * srsp_r;
  assign hzsc_p = hz1_r * srcp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_r    <= pr[N].neg ? SCW'(-pr[N].y) : SCW'(pr[N].y);
      cp_r    <= pr[N].neg ? SCW'(-pr[N].x) : SCW'(pr[N].x);
      sr_r    <= rr[N].neg ? SCW'(-rr[N].y) : SCW'(rr[N].y);
      cr_r    <= rr[N].neg ? SCW'(-rr[N].x) : SCW'(rr[N].x);
      hn_r    <= hr_r[N];

      srsp_r  <= srsp_s[SCW-1:0];
      srcp_r  <= srcp_s[SCW-1:0];
      hxcp_r  <= hxcp_p;
      hzsp_r  <= hzsp_p;
      hycr_r  <= hycr_p;
      hx1_r   <= hn_r.hx;
      hz1_r   <= hn_r.hz;

      xh2_r   <= hxcp_r + hzsp_r;
      hxss_r  <= hxss_p;
      hzsc_r  <= hzsc_p;
      hycr2_r <= hycr_r;

      xh3_r   <= xh2_r;
      yh3_r   <= hxss_r + hycr2_r - hzsc_r;

      yv0_r   <= tcc_pkg::prerot(y_y, y_x);
    end
  end

  assign y_y = {{(VW-PW){yh3_r[PW-1]}}, yh3_r};
  assign y_x = {{(VW-PW){xh3_r[PW-1]}}, xh3_r};

  genvar y;
  generate
    for (y = 0; y < N; y++) begin : g_yaw
      if (y == 0) begin : g_first
        tcc_vec_cell u_cell (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(y)),
          .ang   (tcc_pkg::atan_q30(SHW'(y))),
          .d     (yv0_r),
          .q     (yv[1])
        );
      end else begin : g_next
        tcc_vec_cell u_cell (
          .clk   (clk),
          .en    (adv),
          .shamt (SHW'(y)),
          .ang   (tcc_pkg::atan_q30(SHW'(y))),
          .d     (yv[y]),
          .q     (yv[y+1])
        );
      end
    end
  endgenerate

  assign yaw_a = yv[N].zero ? '0 : yv[N].z;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pitch_r <= tcc_pkg::to_out(ang_r[ANGN-1].pitch);
      out_roll_r  <= tcc_pkg::to_out(ang_r[ANGN-1].roll);
      out_yaw_r   <= tcc_pkg::to_out(yaw_a);
    end
  end

  assign out_pitch_angle = out_pitch_r;
  assign out_roll_angle  = out_roll_r;
  assign out_yaw_angle   = out_yaw_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_angle <= tcc_pkg::OUT_LIM16) &&
                  (out_yaw_angle >= -tcc_pkg::OUT_LIM16))
    else $error("heading outside +-pi");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= tcc_pkg::OUT_LIM16) &&
                  (out_pitch_angle >= -tcc_pkg::OUT_LIM16))
    else $error("pitch outside +-pi");

endmodule

`default_nettype wire
